### sv/xmd_pkg.sv
// Shared constants and helpers for the XML message deframer.
`default_nettype none
package xmd_pkg;

    localparam logic [7:0] CHAR_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_GT    = 8'h3E;  // '>'

    // Element name character: A-Z, a-z, 0-9 or underscore.
    function automatic logic is_name_char(input logic [7:0] c);
        is_name_char = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                       (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
    endfunction

endpackage
`default_nettype wire

### sv/xmd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module xmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                 i_wr_data,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

### sv/xml_message_deframer.sv
// Top level of the XML message deframer: name store, end-tag matcher, output register.
`default_nettype none
// The block takes one byte per transaction and returns one transaction per byte,
// the byte itself plus two flags, at a sustained rate of one byte per cycle while the
// output is not stalled; accepted bytes load the output register. The first '<'
// followed by name characters (A-Z, a-z, 0-9, '_') opens the leading element;
// its name is written into a MAX_NAME_LEN x 8 RAM, one character per byte. After
// the name the bytes are matched against "</name>"; message_end is set on the
// '>' that completes it, and the search for a new element begins again. A name
// that would exceed MAX_NAME_LEN characters sets name_too_long on that character
// and the element is dropped. The rate is set by the name RAM: its read address
// is the next expected name position, issued on the edge that accepts a byte so
// the character to compare is ready when the following byte arrives. The input
// stalls only while a completed transaction is held at the output by i_out_stall.
// The name RAM needs no clearing after reset: only stored positions are read.
module xml_message_deframer #(
    parameter int MAX_NAME_LEN = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_data_byte,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output logic      [7:0] o_out_byte,
    output logic            o_message_end,
    output logic            o_name_too_long,
    input  wire logic       i_out_stall
);

    localparam int AW = $clog2(MAX_NAME_LEN > 1 ? MAX_NAME_LEN : 2);
    localparam int LW = $clog2(MAX_NAME_LEN + 1);
    localparam int PW = $clog2(MAX_NAME_LEN + 3);

    localparam logic [1:0] PH_SEEK = 2'd0;
    localparam logic [1:0] PH_NAME = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    logic [1:0]    r_phase, n_phase;
    logic [LW-1:0] r_len, n_len;
    logic [PW-1:0] r_match, n_match;

    logic       accept;
    logic       name_char;
    logic       end_hit;
    logic       too_long;
    logic       body_ok;
    logic       body_done;
    logic [7:0] rd_char;
    logic       wr_en;
    logic [PW-1:0] rd_pos;
    logic [PW-1:0] rd_idx;
    logic [PW:0]   len_plus2;

    assign o_in_stall = o_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign name_char  = xmd_pkg::is_name_char(i_data_byte);
    assign len_plus2  = (PW+1)'(r_len) + (PW+1)'(2);

    // End-tag matcher for one body byte at the stored match position.
    always_comb begin
        body_done = 1'b0;
        if (r_phase != PH_BODY || r_match == '0) begin
            body_ok = (i_data_byte == xmd_pkg::CHAR_LT);
        end else if (r_match == PW'(1)) begin
            body_ok = (i_data_byte == xmd_pkg::CHAR_SLASH);
        end else if ((PW+1)'(r_match) < len_plus2) begin
            body_ok = (i_data_byte == rd_char);
        end else begin
            body_ok   = (i_data_byte == xmd_pkg::CHAR_GT);
            body_done = body_ok;
        end
    end

    // Next state for the accepted byte.
    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_match  = r_match;
        wr_en    = 1'b0;
        end_hit  = 1'b0;
        too_long = 1'b0;
        if (accept) begin
            unique case (r_phase)
                PH_NAME: begin
                    if (name_char) begin
                        if (r_len < LW'(MAX_NAME_LEN)) begin
                            wr_en = 1'b1;
                            n_len = r_len + LW'(1);
                        end else begin
                            too_long = 1'b1;
                            n_phase  = PH_SEEK;
                            n_len    = '0;
                        end
                    end else if (r_len == '0) begin
                        // empty name: another '<' restarts the candidate
                        if (i_data_byte != xmd_pkg::CHAR_LT) begin
                            n_phase = PH_SEEK;
                        end
                    end else begin
                        // name ends; this byte is the first one matched at position 0
                        n_phase = PH_BODY;
                        n_match = (i_data_byte == xmd_pkg::CHAR_LT) ? PW'(1) : '0;
                    end
                end
                PH_BODY: begin
                    if (body_done) begin
                        end_hit = 1'b1;
                        n_match = '0;
                        n_phase = PH_SEEK;
                        n_len   = '0;
                    end else if (body_ok) begin
                        n_match = r_match + PW'(1);
                    end else begin
                        n_match = (i_data_byte == xmd_pkg::CHAR_LT) ? PW'(1) : '0;
                    end
                end
                default: begin
                    n_phase = PH_SEEK;
                    if (i_data_byte == xmd_pkg::CHAR_LT) begin
                        n_phase = PH_NAME;
                        n_len   = '0;
                        n_match = '0;
                    end
                end
            endcase
        end
    end

    // Prefetch the name character for the next match position.
    assign rd_pos = n_match;
    assign rd_idx = rd_pos - PW'(2);

    xmd_ram #(
        .WIDTH(8),
        .DEPTH(MAX_NAME_LEN)
    ) u_name_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_len[AW-1:0]),
        .i_wr_data(i_data_byte),
        .i_rd_addr(rd_idx[AW-1:0]),
        .o_rd_data(rd_char)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_len   <= '0;
            r_match <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_match <= n_match;
        end
    end

    // Output register: load on accept, drop when the transaction is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (accept) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_out_byte      <= i_data_byte;
            o_message_end   <= end_hit;
            o_name_too_long <= too_long;
        end
    end

    // The two flags never mark the same transaction.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_message_end && o_name_too_long))
        else $error("message_end and name_too_long both set");

    // The match position never runs past the closing '>' of the end tag.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> ((PW+1)'(r_match) <= len_plus2))
        else $error("match position beyond end tag");

    // The stored name length never exceeds the name store.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_NAME_LEN))
        else $error("name length overflow");

    // A stalled input always has a held output behind it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled without a pending output");

endmodule
`default_nettype wire
